// ===== hw/rtl/ddoc_pkg.sv =====
// Shared types, constants and calendar tables for the date day-offset core.
package ddoc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        RegOriginYear  = 2'd0,
        RegOriginMonth = 2'd1,
        RegOriginDay   = 2'd2,
        RegUnused      = 2'd3
    } cfg_reg_t;

    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned DayNumW = 23;
    localparam int unsigned OffsetW = 23;
    localparam int unsigned CfgW    = 14;

    // floor(y / 100) == (y * Recip100) >> Recip100Shift for any 14-bit y
    localparam int unsigned Recip100      = 5243;
    localparam int unsigned Recip100Shift = 19;
    localparam int unsigned ProdW         = 27;

    localparam int signed OffsetMax = 4194303;
    localparam int signed OffsetMin = -4194304;

    typedef logic [8:0] mstart_t;

    // Days before month m in a common year; months past twelve count 31.
    localparam mstart_t MonthStart [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
    };

    // Stage enables for the day-number pipeline
    typedef struct packed {
        logic en_a;
        logic en_b;
    } stage_en_t;

    // Length of month m; zero for codes that are not months
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/date_day_offset_and_check_core.sv =====
// Top level of the date day-offset and legality check core.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid/s_ready   | s_year[13:0] s_month[3:0] s_day[4:0]
//  m_      | out | m_valid/m_ready   | m_day_offset[22:0] m_is_legal m_before_origin
//  cfg_    | in  | cfg_valid/ready   | cfg_index[1:0] cfg_data[13:0]
//
//  One beat per cycle in, one per cycle out while m_ready is high; each stage is registered.
//  Stages: input reg, products ((y-1)*365, y*recip100), day number, offset + saturate.
//  Each stage has its own valid, so bubbles are squeezed out under m_ready stalls.
//  Origin day number runs in a parallel free-running copy of the day-number unit.
//  aresetn (sync, active low) clears valids and restores origin 1903-01-01.
module date_day_offset_and_check_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ddoc_pkg::YearW-1:0]         s_year,
    input  logic [ddoc_pkg::MonthW-1:0]        s_month,
    input  logic [ddoc_pkg::DayW-1:0]          s_day,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ddoc_pkg::OffsetW-1:0] m_day_offset,
    output logic                               m_is_legal,
    output logic                               m_before_origin,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [ddoc_pkg::CfgW-1:0]          cfg_data
);

    logic [ddoc_pkg::YearW-1:0]  org_year_reg;
    logic [ddoc_pkg::MonthW-1:0] org_month_reg;
    logic [ddoc_pkg::DayW-1:0]   org_day_reg;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, vo_reg, vo_next;
    logic rdy1, rdy2, rdy3, rdyo;

    logic [ddoc_pkg::YearW-1:0]  year1_reg;
    logic [ddoc_pkg::MonthW-1:0] month1_reg, month2_reg, month3_reg;
    logic [ddoc_pkg::DayW-1:0]   day1_reg, day2_reg, day3_reg;
    logic                        before2_reg, before3_reg;
    logic                        before1;

    logic [ddoc_pkg::DayNumW-1:0] dn_in, dn_org;
    logic                         leap_in, leap_org;
    ddoc_pkg::stage_en_t          en_in, en_org;

    logic signed [ddoc_pkg::OffsetW:0]   diff;
    logic signed [ddoc_pkg::OffsetW-1:0] offset_next, offset_reg;
    logic                                legal_next, legal_reg, before_o_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_year_reg  <= 14'd1903;
            org_month_reg <= 4'd1;
            org_day_reg   <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (ddoc_pkg::cfg_reg_t'(cfg_index))
                ddoc_pkg::RegOriginYear:  org_year_reg  <= cfg_data;
                ddoc_pkg::RegOriginMonth: org_month_reg <= cfg_data[ddoc_pkg::MonthW-1:0];
                ddoc_pkg::RegOriginDay:   org_day_reg   <= cfg_data[ddoc_pkg::DayW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    always_comb begin
        rdyo    = !vo_reg || m_ready;
        rdy3    = !v3_reg || rdyo;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
        vo_next = rdyo ? v3_reg  : vo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    assign s_ready = rdy1;

    // stage 1: input register
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            year1_reg  <= s_year;
            month1_reg <= s_month;
            day1_reg   <= s_day;
        end
    end

    assign before1 = {year1_reg, month1_reg, day1_reg}
                   < {org_year_reg, org_month_reg, org_day_reg};

    // stages 2 and 3: side data alongside the day-number unit
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            month2_reg  <= month1_reg;
            day2_reg    <= day1_reg;
            before2_reg <= before1;
        end
        if (rdy3) begin
            month3_reg  <= month2_reg;
            day3_reg    <= day2_reg;
            before3_reg <= before2_reg;
        end
    end

    assign en_in.en_a  = rdy2;
    assign en_in.en_b  = rdy3;
    assign en_org.en_a = 1'b1;
    assign en_org.en_b = 1'b1;

    ddoc_daynum u_dn_in (
        .aclk    (aclk),
        .en      (en_in),
        .year    (year1_reg),
        .month   (month1_reg),
        .day     (day1_reg),
        .day_num (dn_in),
        .leap    (leap_in)
    );

    ddoc_daynum u_dn_org (
        .aclk    (aclk),
        .en      (en_org),
        .year    (org_year_reg),
        .month   (org_month_reg),
        .day     (org_day_reg),
        .day_num (dn_org),
        .leap    (leap_org)
    );

    // stage 4: offset, saturation, legality
    always_comb begin
        diff = $signed({1'b0, dn_in}) - $signed({1'b0, dn_org});
        if (diff > (ddoc_pkg::OffsetW+1)'(ddoc_pkg::OffsetMax)) begin
            offset_next = ddoc_pkg::OffsetW'(ddoc_pkg::OffsetMax);
        end else if (diff < (ddoc_pkg::OffsetW+1)'(ddoc_pkg::OffsetMin)) begin
            offset_next = ddoc_pkg::OffsetW'(ddoc_pkg::OffsetMin);
        end else begin
            offset_next = diff[ddoc_pkg::OffsetW-1:0];
        end
        legal_next = (day3_reg != '0) && !leap_org
                   ? (day3_reg <= ddoc_pkg::month_len(month3_reg, leap_in))
                   : (day3_reg != '0) && (day3_reg <= ddoc_pkg::month_len(month3_reg, leap_in));
    end

    always_ff @(posedge aclk) begin
        if (rdyo) begin
            offset_reg   <= offset_next;
            legal_reg    <= legal_next;
            before_o_reg <= before3_reg;
        end
    end

    assign m_valid         = vo_reg;
    assign m_day_offset    = offset_reg;
    assign m_is_legal      = legal_reg;
    assign m_before_origin = before_o_reg;

endmodule

// ===== hw/rtl/ddoc_daynum.sv =====
// Two-stage day-number unit: closed-form Gregorian day count and leap flag.
module ddoc_daynum (
    input  logic                              aclk,
    input  ddoc_pkg::stage_en_t               en,
    input  logic [ddoc_pkg::YearW-1:0]        year,
    input  logic [ddoc_pkg::MonthW-1:0]       month,
    input  logic [ddoc_pkg::DayW-1:0]         day,
    output logic [ddoc_pkg::DayNumW-1:0]      day_num,
    output logic                              leap
);

    // stage a: products
    logic [ddoc_pkg::DayNumW-1:0] p365_reg, p365_next;
    logic [ddoc_pkg::ProdW-1:0]   prod_reg, prod_next;
    logic [ddoc_pkg::YearW-3:0]   pq4_reg, pq4_next;
    logic [1:0]                   ylo_reg;
    logic                         ynz_reg, ynz_next;
    logic [ddoc_pkg::MonthW-1:0]  month_a_reg;
    logic [ddoc_pkg::DayW-1:0]    day_a_reg;

    // stage b: day number
    logic [ddoc_pkg::DayNumW-1:0] day_num_reg, day_num_next;
    logic                         leap_reg, leap_next;

    logic [ddoc_pkg::YearW-1:0]   prev_year;
    logic [7:0]                   q100;
    logic                         div100;
    logic [7:0]                   qp100;
    logic [ddoc_pkg::DayNumW-1:0] years_days;
    ddoc_pkg::mstart_t            mstart;

    always_comb begin
        ynz_next  = (year != '0);
        prev_year = year - 14'd1;
        p365_next = ynz_next ? ({9'd0, prev_year} * 23'd365) : '0;
        pq4_next  = ynz_next ? prev_year[ddoc_pkg::YearW-1:2] : '0;
        prod_next = {13'd0, year} * ddoc_pkg::ProdW'(ddoc_pkg::Recip100);
    end

    always_ff @(posedge aclk) begin
        if (en.en_a) begin
            p365_reg    <= p365_next;
            prod_reg    <= prod_next;
            pq4_reg     <= pq4_next;
            ylo_reg     <= year[1:0];
            ynz_reg     <= ynz_next;
            month_a_reg <= month;
            day_a_reg   <= day;
        end
    end

    always_comb begin
        q100   = prod_reg[ddoc_pkg::ProdW-1:ddoc_pkg::Recip100Shift];
        // year divisible by 100 iff the fraction bits stay below the reciprocal
        div100 = prod_reg[ddoc_pkg::Recip100Shift-1:0]
                 < ddoc_pkg::Recip100Shift'(ddoc_pkg::Recip100);
        leap_next = ((ylo_reg == 2'd0) && !div100) || (div100 && (q100[1:0] == 2'd0));
        // (year - 1) / 100
        qp100 = ynz_reg ? (div100 ? (q100 - 8'd1) : q100) : 8'd0;
        years_days = p365_reg + ddoc_pkg::DayNumW'(pq4_reg)
                   - ddoc_pkg::DayNumW'(qp100) + ddoc_pkg::DayNumW'(qp100[7:2]);
        mstart = ddoc_pkg::MonthStart[month_a_reg];
        day_num_next = years_days + ddoc_pkg::DayNumW'(mstart)
                     + ddoc_pkg::DayNumW'((month_a_reg > 4'd2) && leap_next)
                     + ddoc_pkg::DayNumW'(day_a_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.en_b) begin
            day_num_reg <= day_num_next;
            leap_reg    <= leap_next;
        end
    end

    assign day_num = day_num_reg;
    assign leap    = leap_reg;

endmodule

// ===== hw/rtl/ddoc_checker.sv =====
// Port-level checker for the date day-offset core, bound to the top level.
module ddoc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ddoc_pkg::OffsetW-1:0]  m_day_offset,
    input logic                          m_is_legal,
    input logic                          m_before_origin,
    input logic                          cfg_ready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_day_offset)
            && $stable(m_is_legal) && $stable(m_before_origin))
        else $error("result beat changed under stall");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // an accepted beat reaches the output while m_ready stays high behind it
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing after pipeline latency");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind date_day_offset_and_check_core ddoc_checker u_ddoc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_day_offset    (m_day_offset),
    .m_is_legal      (m_is_legal),
    .m_before_origin (m_before_origin),
    .cfg_ready       (cfg_ready)
);

// ===== test/tb.sv =====
// Self-checking testbench for the date day-offset and legality check core.
module tb;

    typedef struct packed {
        logic [ddoc_pkg::YearW-1:0]  year;
        logic [ddoc_pkg::MonthW-1:0] month;
        logic [ddoc_pkg::DayW-1:0]   day;
    } date_in_t;

    typedef struct packed {
        logic signed [ddoc_pkg::OffsetW-1:0] offset;
        logic                                legal;
        logic                                earlier;
    } date_verdict_t;

    localparam int DaysBeforeMonth [16] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 396, 427
    };

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [ddoc_pkg::YearW-1:0]          s_year = '0;
    logic [ddoc_pkg::MonthW-1:0]         s_month = '0;
    logic [ddoc_pkg::DayW-1:0]           s_day = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [ddoc_pkg::OffsetW-1:0] m_day_offset;
    logic                                m_is_legal;
    logic                                m_before_origin;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [1:0]                          cfg_index = '0;
    logic [ddoc_pkg::CfgW-1:0]           cfg_data = '0;

    // origin as the block should hold it
    logic [ddoc_pkg::YearW-1:0]  origin_year = 14'd1903;
    logic [ddoc_pkg::MonthW-1:0] origin_month = 4'd1;
    logic [ddoc_pkg::DayW-1:0]   origin_day = 5'd1;

    date_in_t      dates_to_send[$];
    date_verdict_t open_verdicts[$];
    date_in_t      next_date;
    date_verdict_t new_verdict;
    date_verdict_t want;

    bit sender_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int send_gap = 0;
    int recv_stall = 0;
    int mismatches = 0;
    int dates_accepted = 0;
    int verdicts_checked = 0;
    int legal_dates = 0;
    int clamped_offsets = 0;
    int origin_settings = 1;

    date_day_offset_and_check_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_year         (s_year),
        .s_month        (s_month),
        .s_day          (s_day),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_day_offset   (m_day_offset),
        .m_is_legal     (m_is_legal),
        .m_before_origin(m_before_origin),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic bit is_leap_year(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_days(int y, int m);
        int lim;
        case (m)
            2:           lim = is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: lim = 30;
            default:     lim = 31;
        endcase
        return lim;
    endfunction

    // Gregorian day count; raw day added even when out of range
    function automatic int day_count(int y, int m, int d);
        int p;
        int n;
        n = 0;
        if (y > 0) begin
            p = y - 1;
            n = p * 365 + p / 4 - p / 100 + p / 400;
        end
        n += DaysBeforeMonth[m];
        if (m > 2 && is_leap_year(y)) n++;
        return n + d;
    endfunction

    function automatic date_verdict_t predict_verdict(date_in_t dt);
        date_verdict_t v;
        int diff;
        diff = day_count(dt.year, dt.month, dt.day)
             - day_count(origin_year, origin_month, origin_day);
        if (diff > ddoc_pkg::OffsetMax) diff = ddoc_pkg::OffsetMax;
        if (diff < ddoc_pkg::OffsetMin) diff = ddoc_pkg::OffsetMin;
        v.offset = diff[ddoc_pkg::OffsetW-1:0];
        v.legal = dt.month >= 1 && dt.month <= 12 && dt.day >= 1
                  && dt.day <= month_days(dt.year, dt.month);
        if (dt.year != origin_year) v.earlier = dt.year < origin_year;
        else if (dt.month != origin_month) v.earlier = dt.month < origin_month;
        else v.earlier = dt.day < origin_day;
        return v;
    endfunction

    function automatic date_in_t random_date();
        date_in_t dt;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            dt.year = ddoc_pkg::YearW'($urandom_range(1, 9999));
            dt.month = ddoc_pkg::MonthW'($urandom_range(1, 12));
            dt.day = ddoc_pkg::DayW'($urandom_range(1, month_days(dt.year, dt.month)));
        end else if (pick < 8) begin
            // close to the origin, so the ordering flag flips often
            dt.year = ddoc_pkg::YearW'(origin_year + $urandom_range(0, 4) - 2);
            dt.month = $urandom_range(0, 1) ? origin_month
                                            : ddoc_pkg::MonthW'($urandom_range(0, 15));
            dt.day = ddoc_pkg::DayW'(origin_day + $urandom_range(0, 2) - 1);
        end else begin
            dt.year = ddoc_pkg::YearW'($urandom_range(0, 16383));
            dt.month = ddoc_pkg::MonthW'($urandom_range(0, 15));
            dt.day = ddoc_pkg::DayW'($urandom_range(0, 31));
        end
        return dt;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic queue_date(int y, int m, int d);
        date_in_t dt;
        dt.year = ddoc_pkg::YearW'(y);
        dt.month = ddoc_pkg::MonthW'(m);
        dt.day = ddoc_pkg::DayW'(d);
        dates_to_send.push_back(dt);
    endtask

    task automatic write_origin_reg(ddoc_pkg::cfg_reg_t idx, logic [ddoc_pkg::CfgW-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ddoc_pkg::RegOriginYear:  origin_year = value;
            ddoc_pkg::RegOriginMonth: origin_month = value[ddoc_pkg::MonthW-1:0];
            ddoc_pkg::RegOriginDay:   origin_day = value[ddoc_pkg::DayW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_origin(int y, int m, int d);
        write_origin_reg(ddoc_pkg::RegOriginYear, ddoc_pkg::CfgW'(y));
        write_origin_reg(ddoc_pkg::RegOriginMonth, ddoc_pkg::CfgW'(m));
        write_origin_reg(ddoc_pkg::RegOriginDay, ddoc_pkg::CfgW'(d));
        origin_settings++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (dates_to_send.size() != 0 || s_valid || open_verdicts.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    // driver: predicts each date as its beat is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                new_verdict = predict_verdict({s_year, s_month, s_day});
                open_verdicts.push_back(new_verdict);
                dates_accepted++;
                if (new_verdict.legal) legal_dates++;
                if (new_verdict.offset == ddoc_pkg::OffsetMax
                    || new_verdict.offset == ddoc_pkg::OffsetMin)
                    clamped_offsets++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (dates_to_send.size() != 0) begin
                    next_date = dates_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_year <= next_date.year;
                    s_month <= next_date.month;
                    s_day <= next_date.day;
                    if (sender_idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result beats in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (open_verdicts.size() == 0) begin
                    report_mismatch("result beat with no date outstanding");
                end else begin
                    want = open_verdicts.pop_front();
                    verdicts_checked++;
                    if (m_day_offset !== want.offset)
                        report_mismatch($sformatf("day_offset %0d, want %0d",
                                                  m_day_offset, want.offset));
                    if (m_is_legal !== want.legal)
                        report_mismatch($sformatf("is_legal %b, want %b",
                                                  m_is_legal, want.legal));
                    if (m_before_origin !== want.earlier)
                        report_mismatch($sformatf("before_origin %b, want %b",
                                                  m_before_origin, want.earlier));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_idle_on && $urandom_range(0, 7) == 0)
                    recv_stall = $urandom_range(1, 13);
            end
        end
    end

    initial begin
        int ph;
        int y;
        int m;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset origin 1903-01-01
        queue_date(1903, 1, 1);
        queue_date(1902, 12, 31);
        queue_date(1903, 1, 0);
        queue_date(2000, 2, 29);
        queue_date(1900, 2, 29);
        queue_date(2023, 2, 29);
        queue_date(2000, 3, 1);
        queue_date(0, 1, 1);
        queue_date(0, 3, 1);
        queue_date(1903, 0, 5);
        queue_date(1903, 13, 1);
        queue_date(1903, 15, 31);
        queue_date(1903, 4, 31);
        queue_date(1903, 4, 30);
        queue_date(1, 1, 1);
        queue_date(9999, 12, 31);
        queue_date(10000, 1, 1);
        queue_date(16383, 15, 31);
        wait_drained();

        write_origin_reg(ddoc_pkg::RegUnused, 14'h2aaa);
        set_origin(16383, 15, 31);
        queue_date(0, 0, 0);
        queue_date(16383, 15, 31);
        queue_date(16383, 15, 30);
        wait_drained();

        set_origin(0, 0, 0);
        queue_date(0, 0, 0);
        queue_date(0, 0, 1);
        queue_date(0, 2, 29);

        for (ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0: set_origin(1, 1, 1);
                1: set_origin(9999, 12, 31);
                2: set_origin(16383, 15, 31);
                3: set_origin(0, 0, 0);
                4: set_origin(1903, 1, 1);
                5, 7: begin
                    y = $urandom_range(1, 9999);
                    m = $urandom_range(1, 12);
                    set_origin(y, m, $urandom_range(1, month_days(y, m)));
                end
                default: set_origin($urandom_range(0, 16383), $urandom_range(0, 15),
                                    $urandom_range(0, 31));
            endcase
            sender_idle_on = ph != 7 && $urandom_range(0, 3) != 0;
            recv_idle_on = ph != 7 && $urandom_range(0, 3) != 0;
            repeat (213) dates_to_send.push_back(random_date());
        end
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("checked %0d of %0d dates over %0d origin settings",
                 verdicts_checked, dates_accepted, origin_settings);
        $display("%0d legal dates, %0d clamped offsets, %0d mismatches",
                 legal_dates, clamped_offsets, mismatches);
        if (mismatches == 0) begin
            $display("date_day_offset_and_check_core regression: pass");
        end else begin
            $display("date_day_offset_and_check_core regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", open_verdicts.size());
        $display("date_day_offset_and_check_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ddoc_pkg.sv
hw/rtl/ddoc_daynum.sv
hw/rtl/date_day_offset_and_check_core.sv
hw/rtl/ddoc_checker.sv
test/tb.sv
